[rtl/iopmbd_pkg.sv]
package iopmbd_pkg;

    // Access kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_IDLE  = 2'd3
    } t_opcode;

    // Decoded bus region reported with every result
    typedef enum logic [2:0] {
        REG_ROM  = 3'd0,
        REG_RAM  = 3'd1,
        REG_PROM = 3'd2,
        REG_IO   = 3'd3,
        REG_NONE = 3'd4
    } t_region;

    // Where the read byte of a result comes from
    typedef enum logic [1:0] {
        SRC_CONST = 2'd0,
        SRC_ROM   = 2'd1,
        SRC_RAM   = 2'd2
    } t_rd_src;

    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int HOST_ID_W   = 48;
    localparam int HOST_ID_BYTES = HOST_ID_W / BYTE_W;

    localparam int DEF_ROM_BYTES = 8192;
    localparam int DEF_RAM_TOP   = 24576;

    localparam logic [ADDR_W-1:0] RAM_BASE  = 16'h2000;
    localparam logic [ADDR_W-1:0] RAM_END   = 16'h6000;
    localparam logic [ADDR_W-1:0] PROM_LO   = 16'h80b0;
    localparam logic [ADDR_W-1:0] PROM_HI   = 16'h80bf;
    localparam logic [ADDR_W-1:0] IO_LO     = 16'h8001;
    localparam logic [ADDR_W-1:0] IO_HI     = 16'h80ff;
    localparam logic [BYTE_W-1:0] BYTE_NONE = 8'hff;

    // Decoded access held between the memory read and the output register
    typedef struct packed {
        t_region             region;
        t_rd_src             rd_src;
        logic [BYTE_W-1:0]   rd_const;
        logic                io_rd;
        logic                io_wr;
        logic [BYTE_W-1:0]   io_port;
        logic [BYTE_W-1:0]   io_wdata;
    } t_access;

endpackage

[rtl/iopmbd_ram.sv]
module iopmbd_ram
    import iopmbd_pkg::*;
#(
    parameter int WIDTH = BYTE_W,
    parameter int DEPTH = DEF_ROM_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write on enable, registered read that holds between reads
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/iop_memory_bus_decoder.sv]
// Byte bus decoder for an I/O processor. Each input beat is one access (read, write, ROM load
// or idle) and yields exactly one output beat with the read byte, the decoded region and the
// I/O port strobes. ROM and RAM live in single-port synchronous arrays; the host ID PROM is
// built from the host_id register and answers one nibble per address. The block takes one
// beat per clock while the output side is not stalled; each result passes through the
// registered ROM/RAM read and decode register, then through the output register.
// Write host_id only while no beat is in flight.
module iop_memory_bus_decoder
    import iopmbd_pkg::*;
#(
    parameter int ROM_BYTES = DEF_ROM_BYTES,
    parameter int RAM_TOP   = DEF_RAM_TOP
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration: host_id
    input  logic                 i_cfg_we,
    input  logic [HOST_ID_W-1:0] i_cfg_wdata,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] address, [23:16] write_data, [31:24] io_read_data
    input  logic [31:0]          s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]           s_axis_tuser,
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_data, [10:8] region, [11] io_read_strobe, [12] io_write_strobe,
    // [20:13] io_port, [28:21] io_write_data, [31:29] zero
    output logic [31:0]          m_axis_tdata
);

    localparam int ROM_AW    = $clog2(ROM_BYTES);
    localparam int RAM_DEPTH = RAM_TOP - int'(RAM_BASE);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam logic [ADDR_W-1:0] ROM_LIMIT = ADDR_W'(ROM_BYTES);
    localparam logic [ADDR_W-1:0] RAM_LIMIT = ADDR_W'(RAM_TOP);

    logic [HOST_ID_W-1:0] r_host_id;

    logic          r_s1_valid;
    t_access       r_s1;
    t_access       n_s1;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    t_opcode           in_op;
    logic [ADDR_W-1:0] in_addr;
    logic [BYTE_W-1:0] in_wdata;
    logic [BYTE_W-1:0] in_io_rdata;

    logic accept;
    logic s1_move;

    logic              rom_we;
    logic              rom_re;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_off;
    logic [BYTE_W-1:0] rom_rdata;
    logic [BYTE_W-1:0] ram_rdata;

    logic [BYTE_W-1:0] id_bytes [8];
    logic [BYTE_W-1:0] id_sum;
    logic [BYTE_W-1:0] prom_byte;
    logic [BYTE_W-1:0] s1_rdata;

    assign in_op       = t_opcode'(s_axis_tuser);
    assign in_addr     = s_axis_tdata[15:0];
    assign in_wdata    = s_axis_tdata[23:16];
    assign in_io_rdata = s_axis_tdata[31:24];

    // Handshake: the decode stage moves on when the output register is free or drains
    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Build the PROM image: six ID bytes, checksum, complement
    always_comb begin
        for (int i = 0; i < HOST_ID_BYTES; i++) begin
            id_bytes[i] = r_host_id[HOST_ID_W-1-BYTE_W*i -: BYTE_W];
        end
        id_sum = id_bytes[0] ^ id_bytes[1];
        id_sum = {id_sum[BYTE_W-2:0], id_sum[BYTE_W-1]};
        for (int i = 2; i < HOST_ID_BYTES; i++) begin
            id_sum = id_sum ^ id_bytes[i];
            id_sum = {id_sum[BYTE_W-2:0], id_sum[BYTE_W-1]};
        end
        id_bytes[6] = id_sum;
        id_bytes[7] = ~id_sum;
    end

    assign prom_byte = id_bytes[in_addr[3:1]];
    assign ram_off   = in_addr - RAM_BASE;

    // Decode the beat, pick the memory port actions and the result fields
    always_comb begin
        n_s1          = '0;
        n_s1.region   = REG_NONE;
        n_s1.rd_src   = SRC_CONST;
        rom_we        = 1'b0;
        rom_re        = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        if (in_op != OP_IDLE) begin
            priority if (in_addr < RAM_BASE) begin
                n_s1.region = REG_ROM;
            end else if (in_addr < RAM_END) begin
                n_s1.region = REG_RAM;
            end else if (in_op == OP_READ && in_addr >= PROM_LO && in_addr <= PROM_HI) begin
                n_s1.region = REG_PROM;
            end else if (in_addr >= IO_LO && in_addr <= IO_HI) begin
                n_s1.region = REG_IO;
            end else begin
                n_s1.region = REG_NONE;
            end
        end

        unique case (in_op)
            OP_READ: begin
                unique case (n_s1.region)
                    REG_ROM: begin
                        if (in_addr < ROM_LIMIT) begin
                            n_s1.rd_src = SRC_ROM;
                            rom_re      = 1'b1;
                        end else begin
                            n_s1.rd_const = BYTE_NONE;
                        end
                    end
                    REG_RAM: begin
                        if (in_addr < RAM_LIMIT) begin
                            n_s1.rd_src = SRC_RAM;
                            ram_re      = 1'b1;
                        end else begin
                            n_s1.rd_const = BYTE_NONE;
                        end
                    end
                    REG_PROM: begin
                        n_s1.rd_const = in_addr[0] ? {4'h0, prom_byte[7:4]}
                                                   : {4'h0, prom_byte[3:0]};
                    end
                    REG_IO: begin
                        n_s1.rd_const = in_io_rdata;
                        n_s1.io_rd    = 1'b1;
                        n_s1.io_port  = in_addr[BYTE_W-1:0];
                    end
                    default: begin
                        n_s1.rd_const = BYTE_NONE;
                    end
                endcase
            end
            OP_WRITE: begin
                if (n_s1.region == REG_RAM && in_addr < RAM_LIMIT) begin
                    ram_we = 1'b1;
                end
                if (n_s1.region == REG_IO) begin
                    n_s1.io_wr    = 1'b1;
                    n_s1.io_port  = in_addr[BYTE_W-1:0];
                    n_s1.io_wdata = in_wdata;
                end
            end
            OP_LOAD: begin
                rom_we = in_addr < ROM_LIMIT;
            end
            OP_IDLE: begin
                n_s1.region = REG_NONE;
            end
        endcase

        rom_we = rom_we && accept;
        rom_re = rom_re && accept;
        ram_we = ram_we && accept;
        ram_re = ram_re && accept;
    end

    iopmbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_re    (rom_re),
        .i_addr  (in_addr[ROM_AW-1:0]),
        .i_wdata (in_wdata),
        .o_rdata (rom_rdata)
    );

    iopmbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_off[RAM_AW-1:0]),
        .i_wdata (in_wdata),
        .o_rdata (ram_rdata)
    );

    // Merge the array read data into the result
    always_comb begin
        unique case (r_s1.rd_src)
            SRC_ROM: s1_rdata = rom_rdata;
            SRC_RAM: s1_rdata = ram_rdata;
            default: s1_rdata = r_s1.rd_const;
        endcase
    end

    // Hold host_id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_id <= '0;
        end else if (i_cfg_we) begin
            r_host_id <= i_cfg_wdata;
        end
    end

    // Advance the decode stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            r_out_data <= {3'b000, r_s1.io_wdata, r_s1.io_port, r_s1.io_wr, r_s1.io_rd,
                           r_s1.region, s1_rdata};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

[tb/iop_memory_bus_decoder_test.sv]
`timescale 1ns / 1ps

import iopmbd_pkg::*;

localparam int RAM_SPAN = int'(RAM_END) - int'(RAM_BASE);

// One result beat, packed in the order of m_axis_tdata from the top down
typedef struct packed {
    logic [BYTE_W-1:0] io_wdata;
    logic [BYTE_W-1:0] io_port;
    logic              io_wr;
    logic              io_rd;
    t_region           region;
    logic [BYTE_W-1:0] read_data;
} t_bus_result;

// Predicts the result of every accepted access and checks the result beats in order
class bus_decode_predictor;
    logic [BYTE_W-1:0]    rom_img [DEF_ROM_BYTES];
    logic [BYTE_W-1:0]    ram_img [RAM_SPAN];
    logic [HOST_ID_W-1:0] host_id;
    t_bus_result          pending_results [$];
    int                   errors;
    int                   result_count;

    function new();
        host_id      = '0;
        errors       = 0;
        result_count = 0;
    endfunction

    function void set_host_id(logic [HOST_ID_W-1:0] value);
        host_id = value;
    endfunction

    function int pending();
        return pending_results.size();
    endfunction

    // Bytes 0..5 are the ID, most significant first; 6 is the checksum, 7 its complement
    function logic [BYTE_W-1:0] prom_byte(int idx);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] mix;
        if (idx < HOST_ID_BYTES) begin
            return host_id[(HOST_ID_BYTES - 1 - idx) * BYTE_W +: BYTE_W];
        end
        sum = host_id[HOST_ID_W-1 -: BYTE_W];
        for (int k = 1; k < HOST_ID_BYTES; k++) begin
            mix = sum ^ host_id[(HOST_ID_BYTES - 1 - k) * BYTE_W +: BYTE_W];
            sum = {mix[BYTE_W-2:0], mix[BYTE_W-1]};
        end
        return (idx == HOST_ID_BYTES) ? sum : ~sum;
    endfunction

    function t_region region_of(logic [ADDR_W-1:0] addr, bit is_read);
        if (addr < RAM_BASE) return REG_ROM;
        if (addr < RAM_END) return REG_RAM;
        if (is_read && addr >= PROM_LO && addr <= PROM_HI) return REG_PROM;
        if (addr >= IO_LO && addr <= IO_HI) return REG_IO;
        return REG_NONE;
    endfunction

    // Apply one accepted access to the memory images and queue its result
    function void note_access(logic [1:0] user, logic [31:0] data);
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] io_data;
        logic [BYTE_W-1:0] id_b;
        t_bus_result       res;
        op      = t_opcode'(user);
        addr    = data[15:0];
        wdata   = data[23:16];
        io_data = data[31:24];
        res     = '{io_wdata: '0, io_port: '0, io_wr: 1'b0, io_rd: 1'b0,
                    region: REG_NONE, read_data: '0};
        case (op)
            OP_READ: begin
                res.region = region_of(addr, 1'b1);
                case (res.region)
                    REG_ROM: begin
                        res.read_data = (addr < DEF_ROM_BYTES) ? rom_img[addr] : BYTE_NONE;
                    end
                    REG_RAM: begin
                        res.read_data = (addr < DEF_RAM_TOP) ? ram_img[addr - RAM_BASE]
                                                             : BYTE_NONE;
                    end
                    REG_PROM: begin
                        // low nibble of each byte at the even address
                        id_b = prom_byte(int'(addr[3:1]));
                        res.read_data = addr[0] ? {4'h0, id_b[7:4]} : {4'h0, id_b[3:0]};
                    end
                    REG_IO: begin
                        res.read_data = io_data;
                        res.io_rd     = 1'b1;
                        res.io_port   = addr[7:0];
                    end
                    default: begin
                        res.read_data = BYTE_NONE;
                    end
                endcase
            end
            OP_WRITE: begin
                res.region = region_of(addr, 1'b0);
                if (res.region == REG_RAM && addr < DEF_RAM_TOP) begin
                    ram_img[addr - RAM_BASE] = wdata;
                end else if (res.region == REG_IO) begin
                    res.io_wr    = 1'b1;
                    res.io_port  = addr[7:0];
                    res.io_wdata = wdata;
                end
            end
            OP_LOAD: begin
                res.region = region_of(addr, 1'b0);
                if (addr < DEF_ROM_BYTES) begin
                    rom_img[addr] = wdata;
                end
            end
            default: begin
            end
        endcase
        pending_results.push_back(res);
    endfunction

    task report(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task compare_field(string name, logic [BYTE_W-1:0] want_v, logic [BYTE_W-1:0] got_v);
        if (got_v !== want_v) begin
            report($sformatf("result %0d: %s expected %02h, got %02h",
                             result_count, name, want_v, got_v));
        end
    endtask

    task check_result(logic [31:0] beat);
        t_bus_result got;
        t_bus_result want;
        got = t_bus_result'(beat[28:0]);
        if (pending_results.size() == 0) begin
            report($sformatf("result beat %08h with nothing outstanding", beat));
            return;
        end
        want = pending_results.pop_front();
        compare_field("read_data", want.read_data, got.read_data);
        compare_field("region", {5'b0, want.region}, {5'b0, got.region});
        compare_field("io_read_strobe", {7'b0, want.io_rd}, {7'b0, got.io_rd});
        compare_field("io_write_strobe", {7'b0, want.io_wr}, {7'b0, got.io_wr});
        compare_field("io_port", want.io_port, got.io_port);
        compare_field("io_write_data", want.io_wdata, got.io_wdata);
        compare_field("padding", 8'h00, {5'b0, beat[31:29]});
        result_count++;
    endtask
endclass

module iop_memory_bus_decoder_test;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int PHASE_ITEMS     = 540;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [HOST_ID_W-1:0] i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic [1:0]           s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;

    bus_decode_predictor predictor = new();

    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    // Addresses that have been loaded or written, so reads never hit an empty byte
    bit                rom_loaded  [DEF_ROM_BYTES];
    bit                ram_written [RAM_SPAN];
    logic [ADDR_W-1:0] rom_addrs [$];
    logic [ADDR_W-1:0] ram_addrs [$];

    logic [ADDR_W-1:0] boundary_addrs [6] = '{16'h6000, 16'h7fff, 16'h8000, 16'h80af,
                                              16'h80c0, 16'h8100};

    iop_memory_bus_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sample both handshakes, stall the result side, watch for a hung bus
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predictor.note_access(s_axis_tuser, s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            predictor.check_result(m_axis_tdata);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("iop_memory_bus_decoder_test: FAIL");
            $finish;
        end
    end

    // Drive one access beat and hold it until it is taken
    task automatic issue_access(t_opcode op, logic [ADDR_W-1:0] addr,
                                logic [BYTE_W-1:0] wdata, logic [BYTE_W-1:0] io_data);
        if (op == OP_LOAD && addr < DEF_ROM_BYTES && !rom_loaded[addr]) begin
            rom_loaded[addr] = 1'b1;
            rom_addrs.push_back(addr);
        end
        if (op == OP_WRITE && addr >= RAM_BASE && addr < RAM_END && addr < DEF_RAM_TOP &&
            !ram_written[addr - RAM_BASE]) begin
            ram_written[addr - RAM_BASE] = 1'b1;
            ram_addrs.push_back(addr);
        end
        while ($urandom_range(99) < tx_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {io_data, wdata, addr};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic settle_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (predictor.pending() != 0) @(posedge i_clk);
    endtask

    task automatic program_host_id(logic [HOST_ID_W-1:0] value);
        settle_bus();
        // let the two-stage pipeline empty
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        predictor.set_host_id(value);
    endtask

    function automatic bit is_empty_byte(logic [ADDR_W-1:0] addr);
        if (addr < RAM_BASE) return (addr < DEF_ROM_BYTES) && !rom_loaded[addr];
        if (addr < RAM_END) return (addr < DEF_RAM_TOP) && !ram_written[addr - RAM_BASE];
        return 1'b0;
    endfunction

    // Build and send one random access; idle beats do not count as work
    task automatic random_access(output bit counted);
        int                pick;
        t_opcode           op;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] io_data;
        pick    = $urandom_range(99);
        addr    = ADDR_W'($urandom);
        wdata   = BYTE_W'($urandom);
        io_data = BYTE_W'($urandom);
        counted = 1'b1;
        if (pick < 45) begin
            op = OP_READ;
            case ($urandom_range(5))
                0: if (rom_addrs.size() != 0) addr = rom_addrs[$urandom_range(rom_addrs.size()-1)];
                1: if (ram_addrs.size() != 0) addr = ram_addrs[$urandom_range(ram_addrs.size()-1)];
                2: addr = PROM_LO | ADDR_W'($urandom_range(15));
                3: addr = ADDR_W'($urandom_range(IO_HI, IO_LO));
                4: ;
                default: addr = boundary_addrs[$urandom_range(5)];
            endcase
            // steer away from bytes nobody stored yet
            if (is_empty_byte(addr)) begin
                addr = PROM_LO | ADDR_W'($urandom_range(15));
            end
        end else if (pick < 70) begin
            op = OP_WRITE;
            pick = $urandom_range(9);
            if (pick < 6) begin
                addr = ADDR_W'($urandom_range(RAM_END - 1, RAM_BASE));
            end else if (pick < 8) begin
                addr = ADDR_W'($urandom_range(IO_HI, IO_LO));
            end
        end else if (pick < 90) begin
            op = OP_LOAD;
            if ($urandom_range(9) < 8) begin
                addr = ADDR_W'($urandom_range(DEF_ROM_BYTES - 1, 0));
            end
        end else begin
            op      = OP_IDLE;
            counted = 1'b0;
        end
        issue_access(op, addr, wdata, io_data);
    endtask

    task automatic run_phase(logic [HOST_ID_W-1:0] id_value, int gap_pct, int stall_pct);
        int done_items;
        bit counted;
        done_items = 0;
        program_host_id(id_value);
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        while (done_items < PHASE_ITEMS) begin
            random_access(counted);
            if (counted) done_items++;
            // hold off once per phase until the result side catches up
            if (done_items == PHASE_ITEMS / 2 && counted) settle_bus();
        end
    endtask

    initial begin
        tx_gap_pct   = 36;
        rx_stall_pct = 77;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        program_host_id(48'h0123_4567_89ab);

        // Region edges, ignored writes, PROM nibbles, I/O strobes, idle beat
        issue_access(OP_LOAD,  16'h0000, 8'hff, 8'h00);
        issue_access(OP_LOAD,  16'h1fff, 8'h00, 8'hff);
        issue_access(OP_WRITE, 16'h0000, 8'h12, 8'h00);
        issue_access(OP_READ,  16'h0000, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h1fff, 8'hff, 8'hff);
        issue_access(OP_WRITE, 16'h2000, 8'ha5, 8'h00);
        issue_access(OP_WRITE, 16'h5fff, 8'h5a, 8'h00);
        issue_access(OP_READ,  16'h2000, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h5fff, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h6000, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h8000, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h8001, 8'h00, 8'hff);
        issue_access(OP_READ,  16'h80af, 8'hff, 8'h00);
        issue_access(OP_READ,  16'h80b0, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h80bf, 8'h00, 8'h00);
        issue_access(OP_READ,  16'h80c0, 8'h00, 8'h3c);
        issue_access(OP_READ,  16'h80ff, 8'h00, 8'hc3);
        issue_access(OP_READ,  16'h8100, 8'h00, 8'h00);
        issue_access(OP_READ,  16'hffff, 8'h00, 8'h00);
        issue_access(OP_WRITE, 16'h80b5, 8'hc3, 8'h00);
        issue_access(OP_WRITE, 16'h8000, 8'hff, 8'h00);
        issue_access(OP_WRITE, 16'hffff, 8'hff, 8'hff);
        issue_access(OP_LOAD,  16'h2000, 8'h77, 8'h00);
        issue_access(OP_LOAD,  16'h80b0, 8'h88, 8'h00);
        issue_access(OP_IDLE,  16'hffff, 8'hff, 8'hff);

        run_phase(48'hffff_ffff_ffff, 36, 77);
        run_phase(48'h0000_0000_0000, 77, 36);
        run_phase({16'($urandom), 32'($urandom)}, 0, 0);

        // Drain, then give a late or extra beat time to show up
        settle_bus();
        repeat (8) @(posedge i_clk);
        if (predictor.pending() != 0) begin
            predictor.report($sformatf("%0d results never arrived", predictor.pending()));
        end
        if (predictor.errors == 0) begin
            $display("iop_memory_bus_decoder_test: PASS");
        end else begin
            $display("iop_memory_bus_decoder_test: FAIL");
        end
        $finish;
    end

endmodule
